// ===== hw/rtl/wasc_pkg.sv =====
// Shared types, register map and constants for the wheel anti-slip correction block.
package wasc_pkg;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;
    logic signed [15:0] phase_current;
    logic               meas_fresh;
  } request_t;

  typedef struct packed {
    logic signed [15:0] corrected_speed;
    logic               stall_relief_applied;
  } result_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_CLAMP = 2'd1,
    MODE_PROP  = 2'd2,
    MODE_STALL = 2'd3
  } mode_t;

  localparam int unsigned ADDR_W = 5;

  // register index, taken from paddr[4:2]
  localparam logic [2:0] REG_MODE          = 3'd0;
  localparam logic [2:0] REG_SLIP_LIMIT    = 3'd1;
  localparam logic [2:0] REG_GAIN          = 3'd2;
  localparam logic [2:0] REG_CAP_FRACTION  = 3'd3;
  localparam logic [2:0] REG_STALL_CURRENT = 3'd4;
  localparam logic [2:0] REG_RELIEF_FACTOR = 3'd5;

  localparam mode_t       MODE_RESET          = MODE_PROP;
  localparam logic [15:0] SLIP_LIMIT_RESET    = 16'd1229;
  localparam logic [15:0] GAIN_RESET          = 16'd6554;
  localparam logic [15:0] CAP_FRACTION_RESET  = 16'd8192;
  localparam logic [14:0] STALL_CURRENT_RESET = 15'd3000;
  localparam logic [15:0] RELIEF_FACTOR_RESET = 16'd32768;

  localparam logic [16:0] SAT_POS_MAG = 17'd32767;
  localparam logic [16:0] SAT_NEG_MAG = 17'd32768;

endpackage

// ===== hw/rtl/wheel_anti_slip_correction_top.sv =====
// Wheel anti-slip correction: six-stage pipelined datapath with APB register port.
//
// Usage:
//   Request channel: drive request and pulse start; a request is taken at each
//   rising edge where start is high and busy is low. busy stays low, so a new
//   request may be issued every cycle.
//   Result channel: done is high for exactly one cycle with result valid; the
//   receiver must take it then. Results leave in request order.
//   A taken request reaches its result through six register stages.
//   Throughput: one request per cycle.
//   Latency is set by the pipeline depth only; no stage has more than one
//   16x16 or 17x16 multiply or one wide compare in series.
//   Registers: APB port, register i at byte address 4*i, pready always high.
//   Write registers only when no request is in flight.
//   Reset (rst, synchronous): pipeline emptied, registers return to defaults
//   (mode proportional, slip_limit 1229, gain 6554, cap_fraction 8192,
//   stall_current 3000, relief_factor 32768).
//   The receiver cannot stall, so nothing is ever held back or dropped.
module wheel_anti_slip_correction_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  wasc_pkg::request_t        request,
  output logic                      done,
  output wasc_pkg::result_t         result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wasc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef struct packed {
    logic               valid;
    logic               active;
    logic signed [15:0] t;
    logic               d_neg;
    logic               d_pos;
    logic               cur_high;
    logic [15:0]        dmag;
    logic [15:0]        at;
    logic [15:0]        denom;
  } s1_t;

  typedef struct packed {
    logic               valid;
    logic               active;
    logic signed [15:0] t;
    logic               d_neg;
    logic               d_pos;
    logic               cur_high;
    logic [27:0]        lhs;
    logic [31:0]        rhs;
    logic [17:0]        cap;
    logic [15:0]        pm;
  } s2_t;

  typedef struct packed {
    logic        valid;
    logic        stalled;
    logic [17:0] res;
  } s3_t;

  typedef struct packed {
    logic        valid;
    logic        stalled;
    logic        neg;
    logic [16:0] mag;
  } s4_t;

  // configuration registers
  wasc_pkg::mode_t mode;
  logic [15:0] slip_limit;
  logic [15:0] gain;
  logic [15:0] cap_fraction;
  logic [14:0] stall_current;
  logic [15:0] relief_factor;

  logic [2:0] reg_index;
  logic       reg_write;

  logic                s0_valid;
  wasc_pkg::request_t  s0_req;
  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  wasc_pkg::result_t   result_next;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign reg_index = paddr[4:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= wasc_pkg::MODE_RESET;
      slip_limit    <= wasc_pkg::SLIP_LIMIT_RESET;
      gain          <= wasc_pkg::GAIN_RESET;
      cap_fraction  <= wasc_pkg::CAP_FRACTION_RESET;
      stall_current <= wasc_pkg::STALL_CURRENT_RESET;
      relief_factor <= wasc_pkg::RELIEF_FACTOR_RESET;
    end else if (reg_write) begin
      case (reg_index)
        wasc_pkg::REG_MODE:          mode          <= wasc_pkg::mode_t'(pwdata[1:0]);
        wasc_pkg::REG_SLIP_LIMIT:    slip_limit    <= pwdata[15:0];
        wasc_pkg::REG_GAIN:          gain          <= pwdata[15:0];
        wasc_pkg::REG_CAP_FRACTION:  cap_fraction  <= pwdata[15:0];
        wasc_pkg::REG_STALL_CURRENT: stall_current <= pwdata[14:0];
        wasc_pkg::REG_RELIEF_FACTOR: relief_factor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      wasc_pkg::REG_MODE:          prdata = {30'd0, mode};
      wasc_pkg::REG_SLIP_LIMIT:    prdata = {16'd0, slip_limit};
      wasc_pkg::REG_GAIN:          prdata = {16'd0, gain};
      wasc_pkg::REG_CAP_FRACTION:  prdata = {16'd0, cap_fraction};
      wasc_pkg::REG_STALL_CURRENT: prdata = {17'd0, stall_current};
      wasc_pkg::REG_RELIEF_FACTOR: prdata = {16'd0, relief_factor};
      default:                     prdata = 32'd0;
    endcase
  end

  // stage 1: difference, magnitudes, current check
  logic [16:0] s1_d;
  logic [16:0] s1_dabs;
  logic [16:0] s1_tabs;
  logic [16:0] s1_cabs;
  always_comb begin
    s1_d    = {s0_req.measured_speed[15], s0_req.measured_speed}
            - {s0_req.target_speed[15], s0_req.target_speed};
    s1_dabs = s1_d[16] ? (~s1_d + 17'd1) : s1_d;
    s1_tabs = s0_req.target_speed[15]
            ? (~{1'b1, s0_req.target_speed} + 17'd1)
            : {1'b0, s0_req.target_speed};
    s1_cabs = s0_req.phase_current[15]
            ? (~{1'b1, s0_req.phase_current} + 17'd1)
            : {1'b0, s0_req.phase_current};
    s1_next.valid    = s0_valid;
    s1_next.active   = (mode != wasc_pkg::MODE_OFF) && s0_req.meas_fresh;
    s1_next.t        = s0_req.target_speed;
    s1_next.d_neg    = s1_d[16];
    s1_next.d_pos    = !s1_d[16] && (s1_d != 17'd0);
    s1_next.cur_high = s1_cabs > {2'b00, stall_current};
    s1_next.dmag     = s1_dabs[15:0];
    s1_next.at       = s1_tabs[15:0];
    s1_next.denom    = (s1_tabs == 17'd0) ? 16'd1 : s1_tabs[15:0];
  end

  // stage 2: threshold, cap and proportional products
  logic [31:0] s2_cap_prod;
  logic [31:0] s2_p_prod;
  always_comb begin
    s2_cap_prod      = cap_fraction * s1.at;
    s2_p_prod        = gain * s1.dmag;
    s2_next.valid    = s1.valid;
    s2_next.active   = s1.active;
    s2_next.t        = s1.t;
    s2_next.d_neg    = s1.d_neg;
    s2_next.d_pos    = s1.d_pos;
    s2_next.cur_high = s1.cur_high;
    s2_next.lhs      = {s1.dmag, 12'd0};
    s2_next.rhs      = slip_limit * s1.denom;
    s2_next.cap      = s2_cap_prod[31:14];
    s2_next.pm       = s2_p_prod[31:16];
  end

  // stage 3: tolerance test, capped correction
  logic        s3_apply;
  logic [15:0] s3_lim;
  logic [17:0] s3_t18;
  always_comb begin
    s3_apply = s2.active && ({4'd0, s2.lhs} >= s2.rhs);
    s3_lim   = ({2'b00, s2.pm} < s2.cap) ? s2.pm : s2.cap[15:0];
    s3_t18   = {{2{s2.t[15]}}, s2.t};
    s3_next.valid   = s2.valid;
    s3_next.res     = s3_t18;
    s3_next.stalled = s3_apply && (mode == wasc_pkg::MODE_STALL)
                    && s2.cur_high && s2.d_neg;
    if (s3_apply) begin
      // clamp mode only backs off free-spin; proportional pulls both ways
      if (s2.d_pos) begin
        s3_next.res = s3_t18 - {2'b00, s3_lim};
      end else if (s2.d_neg && (mode != wasc_pkg::MODE_CLAMP)) begin
        s3_next.res = s3_t18 + {2'b00, s3_lim};
      end
    end
  end

  // stage 4: stall relief scaling on the magnitude
  logic [17:0] s4_abs;
  logic [32:0] s4_prod;
  always_comb begin
    s4_abs          = s3.res[17] ? (~s3.res + 18'd1) : s3.res;
    s4_prod         = s4_abs[16:0] * relief_factor;
    s4_next.valid   = s3.valid;
    s4_next.stalled = s3.stalled;
    s4_next.neg     = s3.res[17];
    s4_next.mag     = s3.stalled ? s4_prod[32:16] : s4_abs[16:0];
  end

  // stage 5: sign restore and saturation
  logic [16:0] out_mag;
  always_comb begin
    if (s4.neg) begin
      out_mag = (s4.mag > wasc_pkg::SAT_NEG_MAG) ? wasc_pkg::SAT_NEG_MAG : s4.mag;
      result_next.corrected_speed = 16'(~out_mag + 17'd1);
    end else begin
      out_mag = (s4.mag > wasc_pkg::SAT_POS_MAG) ? wasc_pkg::SAT_POS_MAG : s4.mag;
      result_next.corrected_speed = out_mag[15:0];
    end
    result_next.stall_relief_applied = s4.stalled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1       <= '0;
      s2       <= '0;
      s3       <= '0;
      s4       <= '0;
      done     <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
      s1       <= s1_next;
      s2       <= s2_next;
      s3       <= s3_next;
      s4       <= s4_next;
      done     <= s4.valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_req <= request;
    result <= result_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("request did not produce a result six cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result strobe without a matching request");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (done && result.stall_relief_applied) |-> $past(s2.d_neg && s2.cur_high, 3))
    else $error("stall relief flagged without negative slip and high current");

  a_stall_mag: assert property (@(posedge clk) disable iff (rst)
    (s4.valid && s4.stalled) |-> (s4.mag <= $past(s4_abs[16:0])))
    else $error("stall relief increased the command magnitude");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the wheel anti-slip correction block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NUM_PHASES     = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  wasc_pkg::request_t request = '0;
  logic        done;
  wasc_pkg::result_t  result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [wasc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wheel_anti_slip_correction_top uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the register file
  wasc_pkg::mode_t cfg_mode = wasc_pkg::MODE_RESET;
  logic [15:0] cfg_slip   = wasc_pkg::SLIP_LIMIT_RESET;
  logic [15:0] cfg_gain   = wasc_pkg::GAIN_RESET;
  logic [15:0] cfg_cap    = wasc_pkg::CAP_FRACTION_RESET;
  logic [14:0] cfg_stall  = wasc_pkg::STALL_CURRENT_RESET;
  logic [15:0] cfg_relief = wasc_pkg::RELIEF_FACTOR_RESET;

  wasc_pkg::result_t pending_corrections[$];
  int      errors = 0;
  bit      idle_on = 1'b1;
  int      quiet_cycles = 0;

  typedef struct {
    wasc_pkg::mode_t    mode;
    logic [15:0]        slip;
    wasc_pkg::request_t req;
    bit                 typed;
    wasc_pkg::result_t  want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // coef * x / 2^sh, truncated toward zero
  function automatic longint scale_toward_zero(longint x, longint coef, int sh);
    longint m;
    m = (mag64(x) * coef) >>> sh;
    return x < 0 ? -m : m;
  endfunction

  function automatic wasc_pkg::result_t correct_speed(wasc_pkg::request_t r);
    longint  t, m, cur, at, denom, d, lhs, rhs, cap, pull, spd;
    wasc_pkg::result_t o;
    t   = r.target_speed;
    m   = r.measured_speed;
    cur = r.phase_current;
    spd = t;
    o.stall_relief_applied = 1'b0;
    if (cfg_mode != wasc_pkg::MODE_OFF && r.meas_fresh) begin
      at    = mag64(t);
      denom = at < 1 ? 1 : at;
      d     = m - t;
      lhs   = mag64(d) <<< 12;
      rhs   = longint'(cfg_slip) * denom;
      if (lhs >= rhs) begin
        cap = (longint'(cfg_cap) * at) >>> 14;
        if (cfg_mode == wasc_pkg::MODE_CLAMP) begin
          // only free-spin (measured above target) is backed off
          if (d > 0) begin
            pull = scale_toward_zero(d, longint'(cfg_gain), 16);
            spd  = t - (pull < cap ? pull : cap);
          end
        end else begin
          pull = scale_toward_zero(-d, longint'(cfg_gain), 16);
          if (pull > cap) pull = cap;
          if (pull < -cap) pull = -cap;
          spd = t + pull;
          if (cfg_mode == wasc_pkg::MODE_STALL && mag64(cur) > longint'(cfg_stall)
              && d < 0) begin
            spd = scale_toward_zero(spd, longint'(cfg_relief), 16);
            o.stall_relief_applied = 1'b1;
          end
        end
      end
    end
    if (spd > 32767) spd = 32767;
    if (spd < -32768) spd = -32768;
    o.corrected_speed = spd[15:0];
    return o;
  endfunction

  function automatic wasc_pkg::request_t mk_request(int t, int m, int c, bit f);
    wasc_pkg::request_t r;
    r.target_speed   = t[15:0];
    r.measured_speed = m[15:0];
    r.phase_current  = c[15:0];
    r.meas_fresh     = f;
    return r;
  endfunction

  function automatic wasc_pkg::result_t mk_result(int c, bit s);
    wasc_pkg::result_t o;
    o.corrected_speed      = c[15:0];
    o.stall_relief_applied = s;
    return o;
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // mostly plausible speed pairs, with some near the tolerance edge and some noise
  function automatic wasc_pkg::request_t rand_request();
    int     t, c;
    longint d, bnd, denom;
    t = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 3) == 0) t = int'($urandom_range(0, 400)) - 200;
    denom = (t < 0 ? -t : t);
    if (denom < 1) denom = 1;
    case ($urandom_range(0, 9))
      0:       d = 0;
      1, 2, 3: d = longint'(int'($urandom_range(0, 4095)) - 2048);
      4, 5: begin
        bnd = (longint'(cfg_slip) * denom) >>> 12;
        d   = bnd + longint'(int'($urandom_range(0, 2)) - 1);
        if ($urandom_range(0, 1)) d = -d;
      end
      6:       d = longint'(int'($urandom_range(0, 65535)) - 32768) - t;
      7:       d = -2 * longint'(t);
      default: d = longint'(int'($urandom_range(0, 255)) - 128);
    endcase
    if ($urandom_range(0, 1)) begin
      c = int'(cfg_stall) + int'($urandom_range(0, 4)) - 2;
      if (c > 20000) c = 20000;
      if ($urandom_range(0, 1)) c = -c;
    end else begin
      c = int'($urandom_range(0, 40000)) - 20000;
    end
    return mk_request(t, clamp16(t + d), c, $urandom_range(0, 7) != 0);
  endfunction

  function automatic logic [31:0] shadow_value(logic [2:0] idx);
    case (idx)
      wasc_pkg::REG_MODE:          return {30'd0, cfg_mode};
      wasc_pkg::REG_SLIP_LIMIT:    return {16'd0, cfg_slip};
      wasc_pkg::REG_GAIN:          return {16'd0, cfg_gain};
      wasc_pkg::REG_CAP_FRACTION:  return {16'd0, cfg_cap};
      wasc_pkg::REG_STALL_CURRENT: return {17'd0, cfg_stall};
      wasc_pkg::REG_RELIEF_FACTOR: return {16'd0, cfg_relief};
      default:                     return 32'd0;
    endcase
  endfunction

  task automatic add_row(wasc_pkg::mode_t md, logic [15:0] slip, int t, int m, int c,
                         bit f, bit typed = 1'b0, int wc = 0, bit ws = 1'b0);
    dir_row_t row;
    row.mode  = md;
    row.slip  = slip;
    row.req   = mk_request(t, m, c, f);
    row.typed = typed;
    row.want  = mk_result(wc, ws);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_readback(logic [2:0] idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, 32'd0, rd);
    if (rd !== shadow_value(idx)) begin
      errors++;
      $display("%0t: register %0d readback expected %h actual %h",
               $time, idx, shadow_value(idx), rd);
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      wasc_pkg::REG_MODE:          cfg_mode   = wasc_pkg::mode_t'(val[1:0]);
      wasc_pkg::REG_SLIP_LIMIT:    cfg_slip   = val[15:0];
      wasc_pkg::REG_GAIN:          cfg_gain   = val[15:0];
      wasc_pkg::REG_CAP_FRACTION:  cfg_cap    = val[15:0];
      wasc_pkg::REG_STALL_CURRENT: cfg_stall  = val[14:0];
      wasc_pkg::REG_RELIEF_FACTOR: cfg_relief = val[15:0];
      default: ;
    endcase
    check_readback(idx);
  endtask

  // lower start and let the pipeline empty
  task automatic drain();
    start <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic issue(wasc_pkg::request_t r, bit typed = 1'b0,
                       wasc_pkg::result_t want = '0);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_corrections.insert(pending_corrections.size(),
                               typed ? want : correct_speed(r));
  endtask

  always @(posedge clk) begin : check_results
    wasc_pkg::result_t want;
    if (!rst && done) begin
      if (pending_corrections.size() == 0) begin
        errors++;
        $display("%0t: unexpected result corrected_speed=%0d stall_relief_applied=%0b",
                 $time, result.corrected_speed, result.stall_relief_applied);
      end else begin
        want = pending_corrections.pop_front();
        if (result.corrected_speed !== want.corrected_speed) begin
          errors++;
          $display("%0t: corrected_speed expected %0d actual %0d",
                   $time, want.corrected_speed, result.corrected_speed);
        end
        if (result.stall_relief_applied !== want.stall_relief_applied) begin
          errors++;
          $display("%0t: stall_relief_applied expected %0b actual %0b",
                   $time, want.stall_relief_applied, result.stall_relief_applied);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (!rst && done) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int          n_items;
    logic [31:0] all_ones;
    all_ones = 32'hFFFF_FFFF;

    // typed rows: pass-through, stale feedback, saturation, mode off, clamp on stall side
    add_row(wasc_pkg::MODE_PROP, 16'd1229, 1000, 1000, 0, 1'b1, 1'b1, 1000, 1'b0);
    add_row(wasc_pkg::MODE_PROP, 16'd1229, -32768, 32767, 0, 1'b0, 1'b1, -32768, 1'b0);
    add_row(wasc_pkg::MODE_PROP, 16'd1229, 32767, -32768, 0, 1'b1, 1'b1, 32767, 1'b0);
    add_row(wasc_pkg::MODE_PROP, 16'd1229, -32768, 32767, 0, 1'b1, 1'b1, -32768, 1'b0);
    add_row(wasc_pkg::MODE_PROP, 16'd1229, 0, 0, 0, 1'b1, 1'b1, 0, 1'b0);
    add_row(wasc_pkg::MODE_PROP, 16'd1229, 0, 1, 20000, 1'b1);
    add_row(wasc_pkg::MODE_PROP, 16'd1229, 1000, 1400, 0, 1'b1);
    add_row(wasc_pkg::MODE_PROP, 16'd1229, 1000, -30000, -20000, 1'b1);
    add_row(wasc_pkg::MODE_OFF, 16'd1229, 12345, -5000, 20000, 1'b1, 1'b1, 12345, 1'b0);
    add_row(wasc_pkg::MODE_OFF, 16'd1229, -1, 32767, -20000, 1'b1, 1'b1, -1, 1'b0);
    add_row(wasc_pkg::MODE_CLAMP, 16'd1229, 1000, 5000, 0, 1'b1);
    add_row(wasc_pkg::MODE_CLAMP, 16'd1229, 1000, 200, 20000, 1'b1, 1'b1, 1000, 1'b0);
    add_row(wasc_pkg::MODE_CLAMP, 16'd1229, -2000, 32767, 0, 1'b1);
    // zero tolerance never counts as within
    add_row(wasc_pkg::MODE_CLAMP, 16'd0, 500, 500, 0, 1'b1, 1'b1, 500, 1'b0);
    add_row(wasc_pkg::MODE_PROP, 16'd0, 500, 500, 0, 1'b1);
    add_row(wasc_pkg::MODE_PROP, 16'd0, -32768, -32768, 0, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, 1000, 500, 20000, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, 1000, 500, -20000, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, 1000, 500, 3000, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, 1000, 500, 3001, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, 1000, 1500, 20000, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, -32768, 32767, -20000, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, 32767, -32768, 20000, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd0, -1, -1, -20000, 1'b1);
    add_row(wasc_pkg::MODE_STALL, 16'd1229, 1000, 500, 20000, 1'b0, 1'b1, 1000, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = wasc_pkg::REG_MODE; i <= wasc_pkg::REG_RELIEF_FACTOR; i++)
      check_readback(i[2:0]);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cfg_mode || dir_rows[i].slip != cfg_slip) begin
        drain();
        reg_write(wasc_pkg::REG_MODE, {30'd0, dir_rows[i].mode});
        reg_write(wasc_pkg::REG_SLIP_LIMIT, {16'd0, dir_rows[i].slip});
      end
      issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == 0) begin
        // every register at its top, with bits beyond the field set
        reg_write(wasc_pkg::REG_MODE, all_ones);
        reg_write(wasc_pkg::REG_SLIP_LIMIT, all_ones);
        reg_write(wasc_pkg::REG_GAIN, all_ones);
        reg_write(wasc_pkg::REG_CAP_FRACTION, all_ones);
        reg_write(wasc_pkg::REG_STALL_CURRENT, all_ones);
        reg_write(wasc_pkg::REG_RELIEF_FACTOR, all_ones);
      end else if (p == 1) begin
        reg_write(wasc_pkg::REG_MODE, {30'd0, wasc_pkg::MODE_STALL});
        reg_write(wasc_pkg::REG_SLIP_LIMIT, 32'd0);
        reg_write(wasc_pkg::REG_GAIN, 32'd0);
        reg_write(wasc_pkg::REG_CAP_FRACTION, 32'd0);
        reg_write(wasc_pkg::REG_STALL_CURRENT, 32'd0);
        reg_write(wasc_pkg::REG_RELIEF_FACTOR, 32'd0);
      end else begin
        reg_write(wasc_pkg::REG_MODE, 32'((p + 2) % 4));
        reg_write(wasc_pkg::REG_SLIP_LIMIT, $urandom_range(0, 1) ? $urandom_range(0, 2048)
                                                                 : $urandom_range(0, 65535));
        reg_write(wasc_pkg::REG_GAIN, $urandom_range(0, 65535));
        reg_write(wasc_pkg::REG_CAP_FRACTION, $urandom_range(0, 65535));
        reg_write(wasc_pkg::REG_STALL_CURRENT,
                  (p == 2) ? 32'd20000 : $urandom_range(0, 20000));
        reg_write(wasc_pkg::REG_RELIEF_FACTOR, $urandom_range(0, 65535));
      end
      idle_on = (p < 8) && (p != 5);
      n_items = (cfg_mode == wasc_pkg::MODE_OFF) ? 60 : 220;
      for (int k = 0; k < n_items; k++) issue(rand_request());
    end

    drain();
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== wheel_anti_slip_correction_top.f =====
hw/rtl/wasc_pkg.sv
hw/rtl/wheel_anti_slip_correction_top.sv
tb/sv/tb_top.sv
